// ----- rtl/b64dec_pkg.sv -----
// Shared types, constants and the character lookup for the Base64 decoder.
// Used by base64_decoder_core; depends on nothing else.
package b64dec_pkg;

   // Depth of the queue of decoded byte groups and its pointer width.
   localparam int unsigned GRP_DEPTH = 4;
   localparam int unsigned GRP_AW    = $clog2(GRP_DEPTH);
   localparam int unsigned GRP_CW    = $clog2(GRP_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Configuration register indexes (paddr bit 2 selects the word).
   typedef enum logic [0:0] {
      REG_ALPHABET_SELECT = 1'b0
   } reg_index_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_BAD_COUNT = 2'd1,
      ERR_BAD_PAD   = 2'd2
   } error_code_type;

   // One entry of the output queue: up to three bytes of one input beat.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;      // bytes to send, 1 to 3
      logic            has_bytes;  // 0 for a bare end marker
      logic            last;
      error_code_type  err;
   } byte_group_type;

   // Returns {hit, sextet}; hit is 0 for characters outside the alphabet.
   function automatic logic [6:0] sextet_lookup(input logic [7:0] c, input logic url);
      logic [6:0] r;
      r = 7'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (url && c == 8'h2D) begin
         r = {1'b1, 6'd62};
      end else if (url && c == 8'h5F) begin
         r = {1'b1, 6'd63};
      end else if (!url && c == 8'h2B) begin
         r = {1'b1, 6'd62};
      end else if (!url && c == 8'h2F) begin
         r = {1'b1, 6'd63};
      end else if (c == PAD_CHAR) begin
         r = {1'b1, 6'd0};
      end
      return r;
   endfunction

endpackage

// ----- rtl/base64_decoder_core.sv -----
// Streaming Base64 decoder: characters in, decoded bytes out, one beat each.
// Depends on b64dec_pkg for the lookup function, group type and codes.
// Usage:
//   The req_ channel carries one character per beat in req_tdata, with
//   req_tlast on the final character of a message. Characters outside the
//   selected alphabet are skipped; '=' counts as a zero-valued pad.
//   The rsp_ channel carries one decoded byte per beat. rsp_tlast marks the
//   final beat of a message, and rsp_tuser carries byte_valid (bit 0) and the
//   error code (bits 2:1, nonzero only on the final beat). A message that
//   yields no byte on its final character still ends with a bare beat whose
//   byte_valid is 0. The alphabet (standard or URL) is chosen by the APB
//   register at byte address 0 and should be changed only while the block is idle.
// Timing:
//   A character is decoded in the cycle it is accepted and its bytes enter a
//   four-entry group queue, a register from which rsp_ is driven.
//   The block accepts one character per cycle as long as the queue has a
//   free entry. The queue drains one byte per cycle while rsp_tready is high,
//   so a stalled receiver fills it and req_tready drops after four pending groups.
//   Synchronous reset empties the queue, clears the message state and
//   selects the standard alphabet.
module base64_decoder_core (
   input  logic        clock,
   input  logic        reset,
   // Input character channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   input  logic        req_tlast,   // last_char
   // Decoded byte channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] data_byte
   output logic [2:0]  rsp_tuser,   // [0] byte_valid, [2:1] error_code
   output logic        rsp_tlast,   // end_of_message
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import b64dec_pkg::*;

   // Configuration.
   logic alpha_ff, alpha_in;

   // Message state.
   logic [2:0][5:0] sextet_ff, sextet_in;
   logic [1:0]      fill_ff, fill_in;
   logic [2:0]      pad_ff, pad_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            any_ff, any_in;
   logic            fin_ff, fin_in;
   logic            perr_ff, perr_in;

   // Output group queue.
   byte_group_type          grp_ff [GRP_DEPTH];
   logic [GRP_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [GRP_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [GRP_CW-1:0]       count_ff, count_in;
   logic [1:0]              idx_ff, idx_in;

   logic            accept;
   logic [6:0]      look;
   logic            hit;
   logic            is_pad;
   logic            quart_done;
   logic [2:0]      pad_next;
   logic [1:0]      n_bytes;
   logic            perr_next;
   logic            any_next;
   logic [1:0]      cnt_next;
   error_code_type  err_next;
   logic            push;
   logic            pop_group;
   logic            rsp_fire;
   byte_group_type  new_grp;
   byte_group_type  head;
   logic            cfg_write;

   // ------------------------------------------------------------------
   // Configuration port: always ready, one register at word 0.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      alpha_in = alpha_ff;
      if (cfg_write && csr_paddr[2] == REG_ALPHABET_SELECT) begin
         alpha_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == REG_ALPHABET_SELECT) begin
         csr_prdata = {31'd0, alpha_ff};
      end
   end

   // ------------------------------------------------------------------
   // Character decode and quartet assembly.
   // ------------------------------------------------------------------
   assign req_tready = (count_ff != GRP_CW'(GRP_DEPTH));
   assign accept     = req_tvalid && req_tready;

   assign look       = sextet_lookup(req_tdata, alpha_ff);
   assign hit        = look[6];
   assign is_pad     = (req_tdata == PAD_CHAR);
   assign quart_done = hit && !fin_ff && (fill_ff == 2'd3);
   assign pad_next   = pad_ff + {2'd0, is_pad};

   // Bytes a completed quartet gives: three less one per pad, none at three
   // or more pads.
   always_comb begin
      n_bytes = 2'd0;
      if (quart_done) begin
         if (pad_next == 3'd0) begin
            n_bytes = 2'd3;
         end else if (pad_next <= 3'd2) begin
            n_bytes = 2'(3'd3 - pad_next);
         end
      end
   end

   assign perr_next = perr_ff || (quart_done && pad_next > 3'd2);
   assign any_next  = any_ff || hit;
   assign cnt_next  = cnt_ff + {1'b0, hit};

   // A bad character count outranks a padding error.
   always_comb begin
      if (!any_next || cnt_next != 2'd0) begin
         err_next = ERR_BAD_COUNT;
      end else if (perr_next) begin
         err_next = ERR_BAD_PAD;
      end else begin
         err_next = ERR_NONE;
      end
   end

   always_comb begin
      new_grp.bytes[0]  = {sextet_ff[0], sextet_ff[1][5:4]};
      new_grp.bytes[1]  = {sextet_ff[1][3:0], sextet_ff[2][5:2]};
      new_grp.bytes[2]  = {sextet_ff[2][1:0], look[5:0]};
      new_grp.has_bytes = (n_bytes != 2'd0);
      new_grp.count     = (n_bytes != 2'd0) ? n_bytes : 2'd1;
      new_grp.last      = req_tlast;
      new_grp.err       = req_tlast ? err_next : ERR_NONE;
   end

   assign push = accept && (n_bytes != 2'd0 || req_tlast);

   always_comb begin
      sextet_in = sextet_ff;
      fill_in   = fill_ff;
      pad_in    = pad_ff;
      cnt_in    = cnt_ff;
      any_in    = any_ff;
      fin_in    = fin_ff;
      perr_in   = perr_ff;
      if (accept) begin
         if (req_tlast) begin
            sextet_in = '0;
            fill_in   = 2'd0;
            pad_in    = 3'd0;
            cnt_in    = 2'd0;
            any_in    = 1'b0;
            fin_in    = 1'b0;
            perr_in   = 1'b0;
         end else if (hit) begin
            cnt_in  = cnt_next;
            any_in  = 1'b1;
            perr_in = perr_next;
            if (!fin_ff) begin
               if (quart_done) begin
                  sextet_in = '0;
                  fill_in   = 2'd0;
                  pad_in    = 3'd0;
                  fin_in    = (pad_next != 3'd0);
               end else begin
                  pad_in  = pad_next;
                  fill_in = fill_ff + 2'd1;
                  for (int k = 0; k < 3; k++) begin
                     if (fill_ff == 2'(k)) begin
                        sextet_in[k] = look[5:0];
                     end
                  end
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Group queue and byte serializer.
   // ------------------------------------------------------------------
   assign head       = grp_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign pop_group  = rsp_fire && (idx_ff == head.count - 2'd1);

   always_comb begin
      unique case (idx_ff)
         2'd0:    rsp_tdata = head.bytes[0];
         2'd1:    rsp_tdata = head.bytes[1];
         2'd2:    rsp_tdata = head.bytes[2];
         default: rsp_tdata = 8'd0;
      endcase
      if (!head.has_bytes) begin
         rsp_tdata = 8'd0;
      end
   end

   assign rsp_tlast = head.last && (idx_ff == head.count - 2'd1);
   assign rsp_tuser = {rsp_tlast ? head.err : ERR_NONE, head.has_bytes};

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + GRP_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop_group ? rd_ptr_ff + GRP_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + GRP_CW'(push) - GRP_CW'(pop_group);
      idx_in    = idx_ff;
      if (pop_group) begin
         idx_in = 2'd0;
      end else if (rsp_fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         grp_ff[wr_ptr_ff] <= new_grp;
      end
      if (reset) begin
         alpha_ff  <= 1'b0;
         sextet_ff <= '0;
         fill_ff   <= 2'd0;
         pad_ff    <= 3'd0;
         cnt_ff    <= 2'd0;
         any_ff    <= 1'b0;
         fin_ff    <= 1'b0;
         perr_ff   <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         idx_ff    <= 2'd0;
      end else begin
         alpha_ff  <= alpha_in;
         sextet_ff <= sextet_in;
         fill_ff   <= fill_in;
         pad_ff    <= pad_in;
         cnt_ff    <= cnt_in;
         any_ff    <= any_in;
         fin_ff    <= fin_in;
         perr_ff   <= perr_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
      end
   end

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= GRP_CW'(GRP_DEPTH))
      else $error("group queue count exceeds its depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != GRP_CW'(GRP_DEPTH))
      else $error("group written into a full queue");

   a_byte_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> idx_ff < head.count)
      else $error("byte index beyond the group size");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with an empty count");

endmodule

// ----- dv/b64dec_checker.sv -----
// Scoreboard for base64_decoder_core: watches the character, byte and APB channels,
// predicts every decoded beat and compares it field by field. Depends on b64dec_pkg.
module b64dec_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   input  logic        req_tlast,   // last_char
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] data_byte
   input  logic [2:0]  rsp_tuser,   // [0] byte_valid, [2:1] error_code
   input  logic        rsp_tlast,   // end_of_message
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_beats,
   output int          checked_beats
);
   import b64dec_pkg::*;

   typedef struct packed {
      logic [7:0]     data_byte;
      logic           byte_valid;
      logic           end_of_message;
      error_code_type err;
   } out_beat_type;

   out_beat_type decoded_beats [$];
   int mismatches = 0;
   int beats_seen = 0;
   int queued     = 0;

   // Shadow of the alphabet register and of the message state.
   logic       url_alphabet = 1'b0;
   logic [5:0] held_sextets [3];
   logic [1:0] quartet_fill;
   logic [2:0] pads_in_quartet;
   logic [1:0] valid_mod4;
   logic       any_valid;
   logic       decode_done;
   logic       pad_fault;

   assign fail_count    = mismatches;
   assign pending_beats = queued;
   assign checked_beats = beats_seen;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < 40) begin
         $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   task automatic clear_message();
      for (int k = 0; k < 3; k++) begin
         held_sextets[k] = 6'd0;
      end
      quartet_fill    = 2'd0;
      pads_in_quartet = 3'd0;
      valid_mod4      = 2'd0;
      any_valid       = 1'b0;
      decode_done     = 1'b0;
      pad_fault       = 1'b0;
   endtask

   // Bit 6 says the character belongs to the alphabet, bits 5:0 carry its value.
   function automatic logic [6:0] char_value(input logic [7:0] c, input logic url);
      if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
      if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 8'd26)};
      if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 8'd52)};
      if (c == (url ? "-" : "+")) return {1'b1, 6'd62};
      if (c == (url ? "_" : "/")) return {1'b1, 6'd63};
      if (c == PAD_CHAR) return {1'b1, 6'd0};
      return 7'd0;
   endfunction

   task automatic decode_char(input logic [7:0] c, input logic last);
      logic [6:0]     hit_value;
      logic [7:0]     group_bytes [3];
      int             n_bytes;
      error_code_type verdict;
      out_beat_type   beat;
      hit_value = char_value(c, url_alphabet);
      n_bytes   = 0;
      verdict   = ERR_NONE;
      if (hit_value[6]) begin
         valid_mod4 = valid_mod4 + 2'd1;
         any_valid  = 1'b1;
         // After a padded quartet characters are only counted, not decoded.
         if (!decode_done) begin
            if (c == PAD_CHAR) pads_in_quartet = pads_in_quartet + 3'd1;
            if (quartet_fill < 2'd3) begin
               held_sextets[quartet_fill] = hit_value[5:0];
               quartet_fill = quartet_fill + 2'd1;
            end else begin
               group_bytes[0] = {held_sextets[0], held_sextets[1][5:4]};
               group_bytes[1] = {held_sextets[1][3:0], held_sextets[2][5:2]};
               group_bytes[2] = {held_sextets[2][1:0], hit_value[5:0]};
               if (pads_in_quartet == 3'd0) begin
                  n_bytes = 3;
               end else if (pads_in_quartet <= 3'd2) begin
                  n_bytes     = 3 - int'(pads_in_quartet);
                  decode_done = 1'b1;
               end else begin
                  pad_fault   = 1'b1;
                  decode_done = 1'b1;
               end
               quartet_fill    = 2'd0;
               pads_in_quartet = 3'd0;
               for (int k = 0; k < 3; k++) begin
                  held_sextets[k] = 6'd0;
               end
            end
         end
      end
      if (last) begin
         // A bad count outranks bad padding.
         if (!any_valid || valid_mod4 != 2'd0) verdict = ERR_BAD_COUNT;
         else if (pad_fault) verdict = ERR_BAD_PAD;
      end
      for (int k = 0; k < n_bytes; k++) begin
         beat.data_byte      = group_bytes[k];
         beat.byte_valid     = 1'b1;
         beat.end_of_message = last && (k == n_bytes - 1);
         beat.err            = beat.end_of_message ? verdict : ERR_NONE;
         decoded_beats.push_back(beat);
      end
      if (last && n_bytes == 0) begin
         beat.data_byte      = 8'd0;
         beat.byte_valid     = 1'b0;
         beat.end_of_message = 1'b1;
         beat.err            = verdict;
         decoded_beats.push_back(beat);
      end
      if (last) clear_message();
   endtask

   always @(posedge clock) begin
      out_beat_type want;
      if (reset) begin
         decoded_beats.delete();
         clear_message();
         url_alphabet = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beats_seen++;
            if (decoded_beats.size() == 0) begin
               report_mismatch("byte beat with nothing expected", rsp_tdata, 0);
            end else begin
               want = decoded_beats.pop_front();
               if (rsp_tdata !== want.data_byte)
                  report_mismatch("data_byte", rsp_tdata, want.data_byte);
               if (rsp_tuser[0] !== want.byte_valid)
                  report_mismatch("byte_valid", rsp_tuser[0], want.byte_valid);
               if (rsp_tuser[2:1] !== want.err)
                  report_mismatch("error_code", rsp_tuser[2:1], want.err);
               if (rsp_tlast !== want.end_of_message)
                  report_mismatch("end_of_message", rsp_tlast, want.end_of_message);
            end
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (reg_index_type'(csr_paddr[2]) == REG_ALPHABET_SELECT)
                  url_alphabet = csr_pwdata[0];
            end else if (csr_prdata !== {31'd0, url_alphabet}) begin
               report_mismatch("alphabet_select read", csr_prdata, url_alphabet);
            end
         end
         if (req_tvalid && req_tready) decode_char(req_tdata, req_tlast);
      end
      queued = decoded_beats.size();
   end

endmodule

// ----- dv/tb_base64_decoder_core.sv -----
// Top of the base64_decoder_core testbench: clock, reset, character stimulus,
// APB alphabet writes and the verdict. Depends on b64dec_pkg and b64dec_checker.
module tb_base64_decoder_core;
   import b64dec_pkg::*;

   localparam logic [2:0] ALPHABET_ADDR = {REG_ALPHABET_SELECT, 2'b00};

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;   // [7:0] in_char
   logic        req_tlast   = 1'b0;   // last_char
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;            // [7:0] data_byte
   logic [2:0]  rsp_tuser;            // [0] byte_valid, [2:1] error_code
   logic        rsp_tlast;            // end_of_message
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending_beats;
   int checked_beats;

   // Handshake pressure, in percent of cycles, for the current phase.
   int src_idle_pct   = 0;
   int sink_stall_pct = 0;
   int src_idle_by_phase  [4] = '{0, 66, 0, 24};
   int sink_stall_by_phase[4] = '{0, 0, 66, 24};

   int chars_sent    = 0;
   int coded_chars   = 0;
   int messages_sent = 0;

   base64_decoder_core dut (.*);

   b64dec_checker scoreboard (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver stalls on a random share of cycles, chosen per phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // Hard stop in case the block hangs on either channel.
   initial begin
      #(8 * 400000);
      $display("Timed out with %0d decoded beats still outstanding.", pending_beats);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Maps a sextet onto its character in the chosen alphabet.
   function automatic logic [7:0] sextet_char(input int unsigned v, input logic url);
      if (v < 26) return 8'(8'h41 + v);
      if (v < 52) return 8'(8'h61 + v - 26);
      if (v < 62) return 8'(8'h30 + v - 52);
      if (v == 62) return url ? "-" : "+";
      return url ? "_" : "/";
   endfunction

   // A character the decoder must skip: control codes and punctuation below
   // the plus sign, bytes above 'z', or the other alphabet's two symbols.
   function automatic logic [7:0] skipped_char(input logic url);
      case ($urandom_range(2))
         0: return 8'($urandom_range(8'h2A));
         1: return 8'($urandom_range(8'hFF, 8'h7B));
         default: begin
            if (url) return $urandom_range(1) ? "+" : "/";
            return $urandom_range(1) ? "-" : "_";
         end
      endcase
   endfunction

   // Presents one character and holds it until the decoder takes it. The
   // sender may first go idle for a random number of cycles; tvalid stays
   // high across back-to-back beats.
   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
   endtask

   task automatic send_text(input string s, input logic last_at_end);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], last_at_end && (i == s.len() - 1));
      end
   endtask

   // One APB transfer: setup phase, then access until pready, then idle with
   // psel low so that back-to-back transfers each start with a clean setup.
   task automatic csr_access(input logic write, input logic [2:0] addr,
                             input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Lets the decoder run dry: every predicted beat has come out, and the bench
   // then waits on for characters that yield nothing.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_beats != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic select_alphabet(input logic url);
      wait_for_quiet();
      csr_access(1'b1, ALPHABET_ADDR, {31'd0, url});
      csr_access(1'b0, ALPHABET_ADDR, 32'd0);
   endtask

   // Builds and sends one random message. Most are well-formed encodings,
   // some with trailing pads, skipped characters mixed in, a truncated tail
   // or a skipped final character. The rest carry three or four pads in one
   // quartet, or are plain byte noise.
   task automatic send_message(input logic url);
      logic [7:0] msg [$];
      int kind;
      int quartets;
      int pads;
      int keep;
      kind = $urandom_range(99);
      if (kind < 70) begin
         quartets = ($urandom_range(3) == 0) ? $urandom_range(12, 5) : $urandom_range(3, 1);
         repeat (4 * quartets) msg.push_back(sextet_char($urandom_range(63), url));
         coded_chars += 4 * quartets;
         pads = $urandom_range(2);
         for (int k = 0; k < pads; k++) begin
            msg[msg.size() - 1 - k] = PAD_CHAR;
         end
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 1)) void'(msg.pop_back());
         end
         repeat ($urandom_range(2)) msg.insert($urandom_range(msg.size()), skipped_char(url));
         if ($urandom_range(6) == 0) msg.push_back(skipped_char(url));
      end else if (kind < 85) begin
         repeat (4 * $urandom_range(2)) begin
            msg.push_back(sextet_char($urandom_range(63), url));
            coded_chars++;
         end
         // A quartet with three or four pads; at most one real character.
         keep = ($urandom_range(1) == 0) ? 4 : $urandom_range(3);
         for (int k = 0; k < 4; k++) begin
            msg.push_back((k == keep) ? sextet_char($urandom_range(63), url) : PAD_CHAR);
         end
         coded_chars += 4;
         repeat ($urandom_range(4)) begin
            msg.push_back(sextet_char($urandom_range(63), url));
            coded_chars++;
         end
      end else begin
         repeat ($urandom_range(10, 1)) begin
            case ($urandom_range(3))
               0: msg.push_back(8'($urandom_range(255)));
               1: msg.push_back(PAD_CHAR);
               default: begin
                  msg.push_back(sextet_char($urandom_range(63), url));
                  coded_chars++;
               end
            endcase
         end
      end
      foreach (msg[i]) begin
         send_char(msg[i], i == msg.size() - 1);
      end
      messages_sent++;
   endtask

   initial begin
      int drain_cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed messages in the standard alphabet, left at its reset value:
      // a clean quartet using the alphabet's edge characters, decoding that
      // stops after a padded quartet while later characters are still
      // counted, a quartet of three pads, both errors at once with skipped
      // bytes 00 and FF around it and a skipped final character.
      send_text("Az0/", 1'b1);
      send_text("QQ==A", 1'b1);
      send_text("===Q", 1'b1);
      send_char(8'h00, 1'b0);
      send_text("===AB", 1'b0);
      send_char(8'hFF, 1'b1);

      // URL alphabet: the plus sign is now skipped, and a lone slash makes
      // a message with no valid character at all.
      select_alphabet(1'b1);
      send_text("-_+Z9", 1'b1);
      send_text("/", 1'b1);
      messages_sent += 6;

      // Random phases, each under its own handshake pressure, alternating
      // the alphabet, so that each setting sees two of the four mixes.
      for (int phase = 0; phase < 4; phase++) begin
         select_alphabet(phase[0]);
         src_idle_pct   = src_idle_by_phase[phase];
         sink_stall_pct = sink_stall_by_phase[phase];
         while (coded_chars < 75 * (phase + 1)) send_message(phase[0]);
      end

      req_tvalid <= 1'b0;
      drain_cycles = 0;
      do begin
         @(posedge clock);
         drain_cycles++;
      end while (pending_beats != 0 && drain_cycles < 5000);
      repeat (8) @(posedge clock);

      if (pending_beats != 0) begin
         $display("%0d decoded beats were predicted but never arrived.", pending_beats);
      end
      $display("Sent %0d characters in %0d messages through both alphabets;", chars_sent,
               messages_sent);
      $display("checked %0d byte beats under idle, sender, receiver and mixed pressure.",
               checked_beats);
      if (fail_count == 0 && pending_beats == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/b64dec_pkg.sv
rtl/base64_decoder_core.sv
dv/b64dec_checker.sv
dv/tb_base64_decoder_core.sv
